### hdl/eot_pkg.sv
// ----------------------------------------------------------------------------
// Entity observation table package
// Widths, status codes and payload types shared by the table design.
// ----------------------------------------------------------------------------
package eot_pkg;

  localparam int TABLE_SLOTS = 512;
  localparam int SLOT_W      = $clog2(TABLE_SLOTS);
  localparam int COUNT_W     = SLOT_W + 1;

  localparam logic [1:0] STATUS_FOUND    = 2'd0;
  localparam logic [1:0] STATUS_INSERTED = 2'd1;
  localparam logic [1:0] STATUS_DROPPED  = 2'd2;

  localparam logic signed [7:0] PEAK_UNKNOWN = -8'sd127;
  localparam logic [31:0]       COUNT_MAX    = 32'hFFFF_FFFF;
  localparam logic [9:0]        MAX_RESET    = 10'd512;

  typedef struct packed {
    logic [63:0]       key_hash;
    logic [2:0]        entity_kind;
    logic signed [7:0] rssi;
    logic [7:0]        channel;
    logic              random_id;
    logic              recovered;
    logic [31:0]       timestamp;
  } sighting_t;

  typedef struct packed {
    logic [8:0]  slot_index;
    logic [1:0]  status;
    logic [31:0] sighting_count;
    logic [9:0]  entity_count;
    logic [31:0] dropped_count;
  } result_t;

  // Per-slot record held beside the key.
  typedef struct packed {
    logic [2:0]        entry_kind;
    logic [31:0]       first_seen;
    logic [31:0]       last_seen;
    logic signed [7:0] last_strength;
    logic signed [7:0] peak_strength;
    logic [7:0]        last_channel;
    logic [1:0]        entry_flags;
    logic [31:0]       sightings;
  } record_t;

endpackage

### hdl/eot_stream_if.sv
// ----------------------------------------------------------------------------
// Entity observation table streams
// Valid/ready channel carrying one sighting or one result per beat.
// ----------------------------------------------------------------------------
interface eot_sighting_if (input logic clk);
  import eot_pkg::*;
  logic      valid;
  logic      ready;
  sighting_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface eot_result_if (input logic clk);
  import eot_pkg::*;
  logic    valid;
  logic    ready;
  result_t data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

### hdl/eot_ram.sv
// ----------------------------------------------------------------------------
// Entity observation table RAM
// Single-port synchronous memory with registered read data.
// ----------------------------------------------------------------------------
module eot_ram #(
  parameter int DEPTH = 512,
  parameter int WIDTH = 8
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);
  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end
endmodule

### hdl/entity_observation_table_unit.sv
// ----------------------------------------------------------------------------
// Entity observation table
// Linear-probing hash table of radio entities with per-entry statistics.
// ----------------------------------------------------------------------------
//  channel    dir  payload
//  sighting   in   key, kind, rssi, channel, flags, timestamp
//  result     out  slot, status, sighting count, entity count, drop count
//  cfg        in   entity limit (cfg_we, cfg_data)
//
// Each probe reads the key memory and then compares the key (READ, CMP); a
// hit or insert adds a record read (REC) and a write-back (WRITE) before the
// result is offered (OUT). After reset a clearing pass over all TABLE_SLOTS
// slots empties the key memory and zeroes the records before the first sighting is
// taken. A stalled result holds the block; the next sighting waits until it
// has gone.
module entity_observation_table_unit (
  input  logic                 clk,
  input  logic                 rst,
  eot_sighting_if.sink         sighting,
  eot_result_if.source         result,
  input  logic                 cfg_we,
  input  logic [9:0]           cfg_data
);
  import eot_pkg::*;

  localparam logic [2:0] ST_CLEAR = 3'd0;
  localparam logic [2:0] ST_IDLE  = 3'd1;
  localparam logic [2:0] ST_READ  = 3'd2;
  localparam logic [2:0] ST_CMP   = 3'd3;
  localparam logic [2:0] ST_REC   = 3'd4;
  localparam logic [2:0] ST_WRITE = 3'd5;
  localparam logic [2:0] ST_OUT   = 3'd6;

  logic [2:0]        state;
  logic [9:0]        entity_limit;
  logic [COUNT_W-1:0] held_count;
  logic [31:0]       drop_total;
  sighting_t         item;
  logic [SLOT_W-1:0] slot;
  logic [COUNT_W-1:0] probes;
  logic              inserting;
  result_t           res;

  logic              key_we, rec_we;
  logic [SLOT_W-1:0] key_addr;
  logic [63:0]       key_wdata, key_rdata;
  record_t           rec_wdata, rec_rdata, rec_new;

  eot_ram #(.DEPTH(TABLE_SLOTS), .WIDTH(64)) u_key_ram (
    .clk(clk), .we(key_we), .addr(key_addr), .wdata(key_wdata), .rdata(key_rdata)
  );
  eot_ram #(.DEPTH(TABLE_SLOTS), .WIDTH($bits(record_t))) u_rec_ram (
    .clk(clk), .we(rec_we), .addr(key_addr), .wdata(rec_wdata), .rdata(rec_rdata)
  );

  assign sighting.ready = (state == ST_IDLE);
  assign result.valid   = (state == ST_OUT);
  assign result.data    = res;

  always_comb begin
    key_we    = 1'b0;
    rec_we    = 1'b0;
    key_addr  = slot;
    key_wdata = item.key_hash;
    rec_wdata = rec_new;
    if (state == ST_CLEAR) begin
      key_we    = 1'b1;
      rec_we    = 1'b1;
      key_wdata = '0;
      rec_wdata = '0;
    end else if (state == ST_WRITE) begin
      key_we = inserting;
      rec_we = 1'b1;
    end
  end

  // Record update; on insert the stale fields are replaced wholesale.
  always_comb begin
    record_t base;
    base = rec_rdata;
    if (inserting) begin
      base               = '0;
      base.entry_kind    = item.entity_kind;
      base.first_seen    = item.timestamp;
      base.peak_strength = item.rssi;
    end
    rec_new               = base;
    rec_new.last_seen     = item.timestamp;
    rec_new.last_strength = item.rssi;
    rec_new.last_channel  = item.channel;
    if (!item.recovered) rec_new.entry_flags[0] = 1'b1;
    if (item.random_id)  rec_new.entry_flags[1] = 1'b1;
    if (item.rssi != 8'sd0 &&
        (base.peak_strength == PEAK_UNKNOWN || item.rssi > base.peak_strength)) begin
      rec_new.peak_strength = item.rssi;
    end
    if (base.sightings != COUNT_MAX) rec_new.sightings = base.sightings + 32'd1;
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= ST_CLEAR;
      slot         <= '0;
      entity_limit <= MAX_RESET;
      held_count   <= '0;
      drop_total   <= '0;
    end else begin
      if (cfg_we) entity_limit <= cfg_data;
      case (state)
        ST_CLEAR: begin
          slot <= slot + 1'b1;
          if (slot == SLOT_W'(TABLE_SLOTS - 1)) state <= ST_IDLE;
        end
        ST_IDLE: begin
          if (sighting.valid) begin
            item      <= sighting.data;
            slot      <= sighting.data.key_hash[SLOT_W-1:0];
            probes    <= '0;
            inserting <= 1'b0;
            if (sighting.data.key_hash == 64'd0) begin
              res   <= '{slot_index: '0, status: STATUS_DROPPED, sighting_count: '0,
                         entity_count: held_count, dropped_count: drop_total};
              state <= ST_OUT;
            end else begin
              state <= ST_READ;
            end
          end
        end
        ST_READ: state <= ST_CMP;
        ST_CMP: begin
          if (key_rdata == item.key_hash) begin
            state <= ST_REC;
          end else if (key_rdata == 64'd0) begin
            if (10'(held_count) < entity_limit) begin
              inserting  <= 1'b1;
              held_count <= held_count + 1'b1;
              state      <= ST_REC;
            end else begin
              drop_total <= drop_total + 32'd1;
              res   <= '{slot_index: '0, status: STATUS_DROPPED, sighting_count: '0,
                         entity_count: held_count, dropped_count: drop_total + 32'd1};
              state <= ST_OUT;
            end
          end else if (probes == COUNT_W'(TABLE_SLOTS - 1)) begin
            drop_total <= drop_total + 32'd1;
            res   <= '{slot_index: '0, status: STATUS_DROPPED, sighting_count: '0,
                       entity_count: held_count, dropped_count: drop_total + 32'd1};
            state <= ST_OUT;
          end else begin
            probes <= probes + 1'b1;
            slot   <= slot + 1'b1;
            state  <= ST_READ;
          end
        end
        ST_REC: state <= ST_WRITE;
        ST_WRITE: begin
          res   <= '{slot_index: 9'(slot),
                     status: inserting ? STATUS_INSERTED : STATUS_FOUND,
                     sighting_count: rec_new.sightings,
                     entity_count: 10'(held_count), dropped_count: drop_total};
          state <= ST_OUT;
        end
        ST_OUT: if (result.ready) state <= ST_IDLE;
        default: state <= ST_IDLE;
      endcase
    end
  end
endmodule

### hdl/eot_checker.sv
// ----------------------------------------------------------------------------
// Entity observation table checker
// Port-level properties of the table, bound to entity_observation_table_unit.
// ----------------------------------------------------------------------------
module eot_checker (
  input logic clk,
  input logic rst,
  input logic in_valid,
  input logic in_ready,
  input logic out_valid,
  input logic out_ready,
  input logic [1:0] status,
  input logic [8:0] slot_index,
  input logic [31:0] sighting_count
);
  import eot_pkg::*;

  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid) else $error("result beat dropped");
  a_no_overlap: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !in_ready) else $error("sighting taken while result pending");
  a_drop_zero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status == STATUS_DROPPED |-> slot_index == 9'd0 && sighting_count == 32'd0)
    else $error("dropped beat carries data");
  a_count_nonzero: assert property (@(posedge clk) disable iff (rst)
    out_valid && status != STATUS_DROPPED |-> sighting_count != 32'd0)
    else $error("live entry with zero count");
endmodule

bind entity_observation_table_unit eot_checker u_eot_checker (
  .clk(clk), .rst(rst),
  .in_valid(sighting.valid), .in_ready(sighting.ready),
  .out_valid(result.valid), .out_ready(result.ready),
  .status(result.data.status), .slot_index(result.data.slot_index),
  .sighting_count(result.data.sighting_count)
);
